// ----- sv/assert_macros.svh -----
// Assertion macros shared by the heading tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define SLHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SLHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/slht_pkg.sv -----
// Types, constants and arctangent table for the slew-limited heading tracker.
package slht_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CMP_W        = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef enum logic [1:0] {
    CFG_PIVOT_X  = 2'd0,
    CFG_PIVOT_Y  = 2'd1,
    CFG_MAX_RATE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [11:0] target_x;
    logic signed [11:0] target_y;
    logic [15:0]        elapsed;
  } slht_in_t;

  typedef struct packed {
    logic [15:0] heading;
    logic        limited;
  } slht_out_t;

  typedef struct packed {
    logic signed [11:0] pivot_x;
    logic signed [11:0] pivot_y;
    logic [15:0]        max_rate;
  } slht_cfg_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] bearing;
    logic [15:0]           lim;
  } slht_job_t;

endpackage

// ----- sv/slew_limited_heading_tracker.sv -----
// Top level of the slew-limited heading tracker: config registers and the front, queue, back chain.
//
//   channel  direction  handshake            payload
//   in_      request    in_valid / in_stall  target_x, target_y, elapsed
//   out_     result     out_valid/out_stall  heading, limited
//   cfg_     write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; a request passes
// one input stage, 30 CORDIC stages, the queue and the output register.
// Only the heading update in the back end depends on the previous request.
// Synchronous active-low reset clears heading to 0 and loads the default config.
// A stalled output fills the 4-entry queue, then holds the CORDIC pipeline and in_stall.
module slew_limited_heading_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  slht_pkg::slht_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slht_pkg::slht_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import slht_pkg::*;

  slht_cfg_t cfg_r;
  slht_job_t f_job, q_job;
  logic      f_valid, f_stall, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pivot_x  <= 12'sd400;
      cfg_r.pivot_y  <= 12'sd300;
      cfg_r.max_rate <= 16'd2731;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PIVOT_X:  cfg_r.pivot_x  <= cfg_data[11:0];
        CFG_PIVOT_Y:  cfg_r.pivot_y  <= cfg_data[11:0];
        CFG_MAX_RATE: cfg_r.max_rate <= cfg_data;
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  slht_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_stall (f_stall),
    .job       (f_job)
  );

  slht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  slht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sv/slht_front.sv -----
// Front end: takes requests, finds the bearing by a pipelined CORDIC and the step limit.
module slht_front (
  input  logic                clk,
  input  logic                rst_n,
  input  slht_pkg::slht_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  slht_pkg::slht_in_t  in_data,
  output logic                job_valid,
  input  logic                job_stall,
  output slht_pkg::slht_job_t job
);
  import slht_pkg::*;

  localparam int STG = CORDIC_STEPS;

  logic signed [31:0] x_r [STG+1];
  logic signed [31:0] y_r [STG+1];
  logic [31:0]        z_r [STG+1];
  logic               zero_r [STG+1];
  logic [15:0]        lim_r [STG+1];
  logic [STG:0]       v_r;

  logic               advance;
  logic signed [12:0] dx, dy, dxa, dya;
  logic               neg;
  logic [31:0]        prod;
  logic [32:0]        zsum;

  assign advance  = !v_r[STG] || !job_stall;
  assign in_stall = !advance;

  always_comb begin
    dx   = 13'(in_data.target_x) - 13'(cfg.pivot_x);
    dy   = 13'(in_data.target_y) - 13'(cfg.pivot_y);
    neg  = dx[12];
    dxa  = neg ? -dx : dx;
    dya  = neg ? -dy : dy;
    prod = 32'(cfg.max_rate) * 32'(in_data.elapsed);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[STG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_r[0]    <= 32'(dxa) <<< 16;
      y_r[0]    <= 32'(dya) <<< 16;
      z_r[0]    <= neg ? 32'h8000_0000 : 32'h0;
      zero_r[0] <= (dx == 13'sd0) && (dy == 13'sd0);
      lim_r[0]  <= prod[31:16];
      for (int i = 0; i < STG; i++) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TURNS[i];
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TURNS[i];
        end
        zero_r[i+1] <= zero_r[i];
        lim_r[i+1]  <= lim_r[i];
      end
    end
  end

  always_comb begin
    zsum        = {1'b0, z_r[STG]} + (33'd1 << (31 - ANGLE_BITS));
    job_valid   = v_r[STG];
    job.bearing = zero_r[STG] ? '0 : zsum[31 -: ANGLE_BITS];
    job.lim     = lim_r[STG];
  end

endmodule

// ----- sv/slht_queue.sv -----
// Short queue between the bearing pipeline and the heading update.
module slht_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_stall,
  input  slht_pkg::slht_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output slht_pkg::slht_job_t pop_data
);
  import slht_pkg::*;

  slht_job_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   cnt_r;
  logic            push, pop;

  assign push_stall = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

`include "assert_macros.svh"
  `SLHT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= (Q_AW+1)'(Q_DEPTH), "queue count over depth")
  `SLHT_ASSERT_NXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "push lost")
  `SLHT_ASSERT_NXT(a_cnt_dec, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "pop lost")

endmodule

// ----- sv/slht_back.sv -----
// Back end: clamps the turn to the step limit, updates the heading, holds the result.
module slht_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  slht_pkg::slht_job_t job,
  output logic                out_valid,
  input  logic                out_stall,
  output slht_pkg::slht_out_t out_data
);
  import slht_pkg::*;

  logic [ANGLE_BITS-1:0] heading_r, heading_nxt;
  logic                  out_valid_r;
  slht_out_t             out_data_r;
  logic [ANGLE_BITS-1:0] du, mag, lim_a;
  logic                  neg, hit, take;

  assign job_ready = !out_valid_r || !out_stall;
  assign take      = job_valid && job_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    du    = job.bearing - heading_r;
    neg   = du[ANGLE_BITS-1];
    mag   = neg ? -du : du;
    lim_a = ANGLE_BITS'(job.lim);
    hit   = CMP_W'(mag) > CMP_W'(job.lim);
    if (!hit) begin
      heading_nxt = job.bearing;
    end else if (neg) begin
      heading_nxt = heading_r - lim_a;
    end else begin
      heading_nxt = heading_r + lim_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (take) begin
      heading_r   <= heading_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.heading <= 16'(heading_nxt);
      out_data_r.limited <= hit;
    end
  end

`include "assert_macros.svh"
  `SLHT_ASSERT_NXT(a_hold_heading, out_valid_r && out_stall, $stable(heading_r),
                   "heading moved while result stalled")
  `SLHT_ASSERT_NXT(a_take_shows, take, out_valid_r, "taken request not shown")
  `SLHT_ASSERT_IMP(a_out_matches, out_valid_r, out_data_r.heading == 16'(heading_r),
                   "result differs from heading state")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the slew-limited heading tracker.
`timescale 1ns / 1ps

module tb;
  import slht_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 40;
  localparam logic [1:0]  CFG_SPARE = 2'd3;

  localparam logic [31:0] TURN_STEP [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  slht_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  slht_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  slht_in_t           pending_ticks[$];
  slht_out_t          heading_due[$];
  logic signed [11:0] piv_x = 12'sd400;
  logic signed [11:0] piv_y = 12'sd300;
  logic [15:0]        turn_rate = 16'd2731;
  logic [15:0]        track_heading = '0;
  slht_in_t           last_req = '0;
  slht_out_t          want;

  logic in_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic pressure_req = 1'b0;
  logic pressure_done = 1'b0;
  int   hold_left = 0;

  int cycles = 0;
  int mismatches = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int clamped_count = 0;
  int in_stall_cycles = 0;
  int reg_writes = 0;

  slew_limited_heading_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] bearing_to(longint dx, longint dy);
    longint      x;
    longint      y;
    longint      nx;
    logic [31:0] z;
    logic [32:0] r;
    int          i;
    if (dx == 0 && dy == 0) return '0;
    z = '0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      z = 32'h80000000;
    end
    x = dx * 65536;
    y = dy * 65536;
    for (i = 0; i < 30; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + TURN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - TURN_STEP[i];
      end
      x = nx;
    end
    r = {1'b0, z} + 33'h8000;
    return r[31:16];
  endfunction

  function automatic slht_out_t next_heading(slht_in_t req);
    longint      dx;
    longint      dy;
    longint      diff;
    longint      limit;
    longint      mag;
    longint      step;
    logic [15:0] du;
    logic [15:0] step_bits;
    slht_out_t   res;
    dx = longint'(req.target_x) - longint'(piv_x);
    dy = longint'(req.target_y) - longint'(piv_y);
    du = bearing_to(dx, dy) - track_heading;
    diff = du[15] ? longint'(du) - 65536 : longint'(du);
    limit = (longint'(turn_rate) * longint'(req.elapsed)) >>> 16;
    mag = (diff < 0) ? -diff : diff;
    step = diff;
    res.limited = 1'b0;
    if (mag > limit) begin
      step = (diff < 0) ? -limit : limit;
      res.limited = 1'b1;
    end
    step_bits = step[15:0];
    res.heading = track_heading + step_bits;
    return res;
  endfunction

  function automatic slht_in_t tick(int tx, int ty, int el);
    slht_in_t r;
    r.target_x = tx[11:0];
    r.target_y = ty[11:0];
    r.elapsed = el[15:0];
    return r;
  endfunction

  function automatic slht_in_t random_request();
    int       kind;
    int       el_kind;
    slht_in_t r;
    r.target_x = 12'($urandom);
    r.target_y = 12'($urandom);
    kind = $urandom_range(9);
    case (kind)
      4, 5: begin
        r.target_x = 12'(int'(piv_x) + int'($urandom_range(6)) - 3);
        r.target_y = 12'(int'(piv_y) + int'($urandom_range(6)) - 3);
      end
      6: r.target_y = piv_y;
      7: r.target_x = piv_x;
      8, 9: begin
        r.target_x = 12'(int'(last_req.target_x) + int'($urandom_range(128)) - 64);
        r.target_y = 12'(int'(last_req.target_y) + int'($urandom_range(128)) - 64);
      end
      default: ;
    endcase
    el_kind = $urandom_range(7);
    case (el_kind)
      0: r.elapsed = '0;
      1: r.elapsed = 16'hFFFF;
      2, 3, 4: r.elapsed = 16'($urandom_range(4095));
      default: r.elapsed = 16'($urandom);
    endcase
    last_req = r;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)",
             what, got, exp_val, results_checked);
    mismatches++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PIVOT_X:  piv_x <= val[11:0];
      CFG_PIVOT_Y:  piv_y <= val[11:0];
      CFG_MAX_RATE: turn_rate <= val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || heading_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic add_random(input int n);
    repeat (n) pending_ticks.push_back(random_request());
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_ticks.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (pressure_req && !pressure_done) begin
      hold_left <= HOLD_CYCLES;
      pressure_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (heading_due.size() == 0) begin
          report_mismatch("result with no request pending", int'(out_data.heading), -1);
        end else begin
          want = heading_due.pop_front();
          if (out_data.heading !== want.heading)
            report_mismatch("heading", int'(out_data.heading), int'(want.heading));
          if (out_data.limited !== want.limited)
            report_mismatch("limited", int'(out_data.limited), int'(want.limited));
          if (want.limited) clamped_count++;
          results_checked++;
        end
      end
      if (in_valid && in_stall) in_stall_cycles++;
      if (in_valid && !in_stall) begin
        want = next_heading(in_data);
        track_heading = want.heading;
        heading_due.push_back(want);
        requests_taken++;
        in_taken <= 1'b1;
      end else begin
        in_taken <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct <= 33;
    recv_idle_pct <= 59;
    pending_ticks.push_back(tick(400, 300, 1000));
    pending_ticks.push_back(tick(-2048, -2048, 65535));
    pending_ticks.push_back(tick(2047, 2047, 65535));
    pending_ticks.push_back(tick(-2048, 2047, 0));
    pending_ticks.push_back(tick(2047, -2048, 65535));
    pending_ticks.push_back(tick(400, -2048, 30000));
    pending_ticks.push_back(tick(400, 2047, 30000));
    pending_ticks.push_back(tick(-2048, 300, 65535));
    pending_ticks.push_back(tick(2047, 300, 0));
    pending_ticks.push_back(tick(401, 300, 100));
    pending_ticks.push_back(tick(399, 300, 100));
    add_random(150);
    drain();

    write_reg(CFG_PIVOT_X, 16'h0000);
    write_reg(CFG_PIVOT_Y, 16'hF000);
    write_reg(CFG_MAX_RATE, 16'hFFFF);
    end_writes();
    pending_ticks.push_back(tick(100, 0, 65535));
    pending_ticks.push_back(tick(-100, 0, 65535));
    pending_ticks.push_back(tick(0, 100, 65535));
    pending_ticks.push_back(tick(0, -100, 65535));
    pending_ticks.push_back(tick(0, 0, 0));
    pending_ticks.push_back(tick(0, 0, 65535));
    pending_ticks.push_back(tick(-2048, -2048, 65535));
    pending_ticks.push_back(tick(2047, 2047, 65535));
    pending_ticks.push_back(tick(1, 0, 65535));
    pending_ticks.push_back(tick(-1, 0, 65535));
    pending_ticks.push_back(tick(2047, -2048, 1));
    add_random(120);
    drain();

    send_idle_pct <= 59;
    recv_idle_pct <= 33;
    write_reg(CFG_PIVOT_X, 16'hA800);
    write_reg(CFG_PIVOT_Y, 16'h07FF);
    write_reg(CFG_MAX_RATE, 16'h0000);
    write_reg(CFG_SPARE, 16'hFFFF);
    end_writes();
    add_random(40);
    drain();

    write_reg(CFG_PIVOT_X, 16'h57FF);
    write_reg(CFG_PIVOT_Y, 16'h0800);
    write_reg(CFG_MAX_RATE, 16'($urandom));
    end_writes();
    pressure_req <= 1'b1;
    add_random(150);
    drain();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_reg(CFG_PIVOT_X, 16'($urandom));
    write_reg(CFG_PIVOT_Y, 16'($urandom));
    write_reg(CFG_MAX_RATE, 16'h0001);
    end_writes();
    add_random(120);
    drain();

    write_reg(CFG_PIVOT_X, 16'($urandom));
    write_reg(CFG_PIVOT_Y, 16'($urandom));
    write_reg(CFG_MAX_RATE, 16'($urandom));
    end_writes();
    add_random(120);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d ticks over %0d register writes; %0d headings checked, %0d rate-clamped",
             requests_taken, reg_writes, results_checked, clamped_count);
    $display("input held back for %0d cycles under output backpressure", in_stall_cycles);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
